FILE: design/tls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_pkg
// Shared widths, command codes and sequencer states of the trimmed latency
// statistics core.
// ----------------------------------------------------------------------------
package tls_pkg;

  localparam int SLOT_COUNT_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 48;

  localparam int CMD_W    = 1;
  localparam int SLOT_W   = 6;
  localparam int SAMPLE_W = 48;
  localparam int COUNT_W  = 32;
  localparam int TOTAL_W  = 64;
  localparam int TIME_W   = 48;

  localparam int TRIM_MIN_CALLS = 4;

  localparam logic [CMD_W-1:0] CMD_RECORD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_SUM,
    ST_REST,
    ST_DIVIDE
  } state_t;

endpackage

FILE: design/trimmed_latency_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_latency_statistics_core
// Per-slot latency statistics table: records samples and reports count,
// extremes and the mean with the two largest and two smallest removed.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------
//   in      | input     | in_valid/in_ready   | command, slot, sample
//   out     | output    | out_valid/out_ready | call_count, min/max_time,
//           |           |                     | trimmed_average, average_valid
//
// a record passes from transfer to result through slot read, then update
// a read with four or more calls runs slot read, accumulation of the cut
// extremes, divider start, the divider iterations and the output load
// other reads pass through slot read and output load; one item is in flight at a time
// after reset a clearing pass over every slot fills the table, in_ready low
// a stalled result holds in the output register; the next item may still be taken
// ----------------------------------------------------------------------------
module trimmed_latency_statistics_core #(
  parameter int SLOT_COUNT   = tls_pkg::SLOT_COUNT_DEF,
  parameter int SAMPLE_WIDTH = tls_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tls_pkg::CMD_W-1:0]    in_command,
  input  logic [tls_pkg::SLOT_W-1:0]   in_slot,
  input  logic [tls_pkg::SAMPLE_W-1:0] in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tls_pkg::COUNT_W-1:0]  out_call_count,
  output logic [tls_pkg::TIME_W-1:0]   out_min_time,
  output logic [tls_pkg::TIME_W-1:0]   out_max_time,
  output logic [tls_pkg::TIME_W-1:0]   out_trimmed_average,
  output logic                         out_average_valid
);

  import tls_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WORD_W = COUNT_W + TOTAL_W + 4 * SW;
  localparam int TOT_LO = COUNT_W;
  localparam int L_LO   = COUNT_W + TOTAL_W;
  localparam int SL_LO  = L_LO + SW;
  localparam int S_LO   = SL_LO + SW;
  localparam int SS_LO  = S_LO + SW;

  localparam logic [63:0]       SMASK   = (64'd1 << SW) - 64'd1;
  localparam logic [SW-1:0]     SW_ONES = '1;
  localparam logic [WORD_W-1:0] EMPTY_WORD =
    {SW_ONES, SW_ONES, {(2 * SW){1'b0}}, {TOTAL_W{1'b0}}, {COUNT_W{1'b0}}};

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [1:0]         step_r, step_nxt;
  logic [TOTAL_W-1:0] acc_r, acc_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic               ok_r, ok_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]      v_r, v_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic [TIME_W-1:0]  out_min_r, out_min_nxt;
  logic [TIME_W-1:0]  out_max_r, out_max_nxt;
  logic [TIME_W-1:0]  out_avg_r, out_avg_nxt;
  logic               out_avv_r, out_avv_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [WORD_W-1:0]  ram_rdata;

  logic               div_start;
  logic               div_busy;
  logic [TOTAL_W-1:0] div_q;

  logic [15:0]        slot_w;
  logic [63:0]        smp_w;
  logic               slot_ok;

  logic [WORD_W-1:0]  entry;
  logic [COUNT_W-1:0] cnt;
  logic [TOTAL_W-1:0] tot;
  logic [SW-1:0]      lg, slg, sm, ssm;

  logic [COUNT_W-1:0] cnt_n;
  logic [TOTAL_W:0]   tot_sum;
  logic [TOTAL_W-1:0] tot_n;
  logic [SW-1:0]      lg_n, slg_n, sm_n, ssm_n;
  logic [WORD_W-1:0]  new_word;

  logic               is_rec_ok;
  logic               avg_ok;
  logic [SW-1:0]      sum_op;
  logic [TOTAL_W-1:0] rest;
  logic [COUNT_W-1:0] divisor;
  logic [63:0]        q_clamp;
  logic [COUNT_W-1:0] res_cnt;
  logic [63:0]        res_min_w, res_max_w;
  logic               out_free;
  logic               out_load;

  // slot store
  tls_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (slot_w[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  tls_div #(
    .DVD_W (TOTAL_W),
    .DVS_W (COUNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rest),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign slot_w  = 16'(in_slot);
  assign smp_w   = 64'(in_sample);
  assign slot_ok = (32'(in_slot) < 32'(SLOT_COUNT));

  // entry fields, empty when the slot is out of range
  assign entry = ok_r ? ram_rdata : EMPTY_WORD;
  assign cnt   = entry[COUNT_W-1:0];
  assign tot   = entry[TOT_LO +: TOTAL_W];
  assign lg    = entry[L_LO +: SW];
  assign slg   = entry[SL_LO +: SW];
  assign sm    = entry[S_LO +: SW];
  assign ssm   = entry[SS_LO +: SW];

  // record update
  assign cnt_n   = (cnt == '1) ? cnt : cnt + COUNT_W'(1);
  assign tot_sum = {1'b0, tot} + (TOTAL_W + 1)'(v_r);
  assign tot_n   = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];

  always_comb begin
    lg_n  = lg;
    slg_n = slg;
    sm_n  = sm;
    ssm_n = ssm;
    if (slg < v_r) begin
      slg_n = v_r;
      if (lg < v_r) begin
        slg_n = lg;
        lg_n  = v_r;
      end
    end
    if (ssm > v_r) begin
      ssm_n = v_r;
      if (sm > v_r) begin
        ssm_n = sm;
        sm_n  = v_r;
      end
    end
  end

  assign new_word = {ssm_n, sm_n, slg_n, lg_n, tot_n, cnt_n};

  // trimmed mean path
  assign is_rec_ok = (cmd_r == CMD_RECORD) && ok_r;
  assign avg_ok    = (cnt >= COUNT_W'(TRIM_MIN_CALLS));
  assign rest      = (tot > acc_r) ? tot - acc_r : '0;
  assign divisor   = cnt - COUNT_W'(TRIM_MIN_CALLS);
  assign q_clamp   = (div_q > SMASK) ? SMASK : div_q;

  always_comb begin
    case (step_r)
      2'd0:    sum_op = lg;
      2'd1:    sum_op = slg;
      2'd2:    sum_op = sm;
      default: sum_op = ssm;
    endcase
  end

  // result fields
  assign res_cnt   = is_rec_ok ? cnt_n : cnt;
  assign res_min_w = 64'(is_rec_ok ? sm_n : sm);
  assign res_max_w = 64'(is_rec_ok ? lg_n : lg);
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    step_nxt    = step_r;
    acc_nxt     = acc_r;
    cmd_nxt     = cmd_r;
    ok_nxt      = ok_r;
    idx_nxt     = idx_r;
    v_nxt       = v_r;
    in_ready    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = new_word;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_avg_nxt = '0;
    out_avv_nxt = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        ram_wdata   = EMPTY_WORD;
        clr_idx_nxt = clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(SLOT_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ram_re    = 1'b1;
          cmd_nxt   = in_command;
          ok_nxt    = slot_ok;
          idx_nxt   = slot_w[IDX_W-1:0];
          v_nxt     = smp_w[SW-1:0];
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if ((cmd_r == CMD_READ) && avg_ok) begin
          acc_nxt   = '0;
          step_nxt  = 2'd0;
          state_nxt = ST_SUM;
        end else if (out_free) begin
          out_load  = 1'b1;
          ram_we    = is_rec_ok;
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        acc_nxt  = acc_r + TOTAL_W'(sum_op);
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ST_REST;
        end
      end
      ST_REST: begin
        div_start = 1'b1;
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        out_avg_nxt = (divisor == '0) ? '0 : q_clamp[TIME_W-1:0];
        out_avv_nxt = 1'b1;
        if (!div_busy && out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);
  assign out_cnt_nxt   = out_load ? res_cnt : out_cnt_r;
  assign out_min_nxt   = out_load ? res_min_w[TIME_W-1:0] : out_min_r;
  assign out_max_nxt   = out_load ? res_max_w[TIME_W-1:0] : out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    acc_r     <= acc_nxt;
    cmd_r     <= cmd_nxt;
    ok_r      <= ok_nxt;
    idx_r     <= idx_nxt;
    v_r       <= v_nxt;
    out_cnt_r <= out_cnt_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
    if (out_load) begin
      out_avg_r <= out_avg_nxt;
      out_avv_r <= out_avv_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_call_count      = out_cnt_r;
  assign out_min_time        = out_min_r;
  assign out_max_time        = out_max_r;
  assign out_trimmed_average = out_avg_r;
  assign out_average_valid   = out_avv_r;

endmodule

FILE: design/tls_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module tls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/tls_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tls_div #(
  parameter int DVD_W = 64,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DVD_W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo_nxt  = {quo_r[DVD_W-2:0], fits};
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: design/tls_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tls_checker
// Port-level checks of the trimmed latency statistics core, bound to the top.
// ----------------------------------------------------------------------------
module tls_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [tls_pkg::COUNT_W-1:0]  out_call_count,
  input logic [tls_pkg::TIME_W-1:0]   out_min_time,
  input logic [tls_pkg::TIME_W-1:0]   out_max_time,
  input logic [tls_pkg::TIME_W-1:0]   out_trimmed_average,
  input logic                         out_average_valid
);

  import tls_pkg::*;

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its count, extremes and mean
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_call_count) && $stable(out_min_time)
      && $stable(out_max_time) && $stable(out_trimmed_average))
    else $error("result payload changed while stalled");

  // one item in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a valid mean needs at least four calls
  a_avg_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_average_valid |-> out_call_count >= COUNT_W'(TRIM_MIN_CALLS))
    else $error("mean flagged valid below four calls");

  // mean is zero unless flagged valid
  a_avg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_average_valid |-> out_trimmed_average == '0)
    else $error("mean non-zero while not valid");

endmodule

bind trimmed_latency_statistics_core tls_checker u_tls_checker (.*);

FILE: sim/trimmed_latency_statistics_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trimmed_latency_statistics_core_test
// Self-checking bench for the latency statistics table. A short table of
// directed commands covers the empty slot, the extreme samples, the exact
// four-call read, ties and the largest trimmed mean. A long random mix of
// records and reads follows, concentrated on a few busy slots. Every result
// is compared field by field against its table row or a behavioural model
// of the slot table kept inside the bench. Both channels idle at random, and
// once the result side holds off long enough for the core to stall its input.
// ----------------------------------------------------------------------------
module trimmed_latency_statistics_core_test;
  import tls_pkg::*;

  localparam int          SLOTS          = SLOT_COUNT_DEF;
  localparam logic [63:0] SAMPLE_MASK    = (64'd1 << SAMPLE_WIDTH_DEF) - 64'd1;
  localparam int          RANDOM_ITEMS   = 1128;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          TAIL_CYCLES    = 100;

  typedef struct packed {
    logic [COUNT_W-1:0] call_count;
    logic [TIME_W-1:0]  min_time;
    logic [TIME_W-1:0]  max_time;
    logic [TIME_W-1:0]  trimmed_average;
    logic               average_valid;
  } slot_report_t;

  typedef struct {
    logic [CMD_W-1:0]    command;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
    bit                  typed;
    slot_report_t        want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command;
  logic [SLOT_W-1:0]   in_slot;
  logic [SAMPLE_W-1:0] in_sample;
  logic                out_valid;
  logic                out_ready;
  logic [COUNT_W-1:0]  out_call_count;
  logic [TIME_W-1:0]   out_min_time;
  logic [TIME_W-1:0]   out_max_time;
  logic [TIME_W-1:0]   out_trimmed_average;
  logic                out_average_valid;

  logic [COUNT_W-1:0] calls_seen [SLOTS];
  logic [63:0]        total_seen [SLOTS];
  logic [63:0]        top_first  [SLOTS];
  logic [63:0]        top_second [SLOTS];
  logic [63:0]        low_first  [SLOTS];
  logic [63:0]        low_second [SLOTS];

  slot_report_t pending_stats[$];
  int           error_count;
  int           items_sent;
  int           results_seen;
  int           averages_seen;

  trimmed_latency_statistics_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_slot             (in_slot),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_call_count      (out_call_count),
    .out_min_time        (out_min_time),
    .out_max_time        (out_max_time),
    .out_trimmed_average (out_trimmed_average),
    .out_average_valid   (out_average_valid)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic slot_report_t stats(logic [COUNT_W-1:0] count, logic [63:0] lo,
                                         logic [63:0] hi, logic [63:0] avg, logic ok);
    slot_report_t r;
    r.call_count      = count;
    r.min_time        = lo[TIME_W-1:0];
    r.max_time        = hi[TIME_W-1:0];
    r.trimmed_average = avg[TIME_W-1:0];
    r.average_valid   = ok;
    return r;
  endfunction

  function automatic stim_row_t make_row(logic [CMD_W-1:0] cmd, int slot, logic [63:0] sample,
                                         bit typed, slot_report_t want);
    stim_row_t r;
    r.command = cmd;
    r.slot    = SLOT_W'(slot);
    r.sample  = sample[SAMPLE_W-1:0];
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic slot_report_t update_slot_stats(logic [CMD_W-1:0] cmd,
                                                     logic [SLOT_W-1:0] slot,
                                                     logic [SAMPLE_W-1:0] sample);
    slot_report_t r;
    logic [63:0]  v;
    logic [63:0]  t;
    logic [63:0]  cut;
    logic [63:0]  rest;
    logic [63:0]  div;
    logic [63:0]  q;
    int           s;
    r = stats('0, SAMPLE_MASK, '0, '0, 1'b0);
    s = int'(slot);
    if (s >= SLOTS) return r;
    v = 64'(sample) & SAMPLE_MASK;
    if (cmd == CMD_RECORD) begin
      if (calls_seen[s] != '1) calls_seen[s] = calls_seen[s] + 1'b1;
      t = total_seen[s] + v;
      total_seen[s] = (t < v) ? '1 : t;
      if (top_second[s] < v) begin
        top_second[s] = v;
        if (top_first[s] < v) begin
          top_second[s] = top_first[s];
          top_first[s]  = v;
        end
      end
      if (low_second[s] > v) begin
        low_second[s] = v;
        if (low_first[s] > v) begin
          low_second[s] = low_first[s];
          low_first[s]  = v;
        end
      end
    end
    r.call_count = calls_seen[s];
    r.min_time   = low_first[s][TIME_W-1:0];
    r.max_time   = top_first[s][TIME_W-1:0];
    if (cmd == CMD_READ && calls_seen[s] >= TRIM_MIN_CALLS) begin
      cut  = top_first[s] + top_second[s] + low_first[s] + low_second[s];
      rest = (total_seen[s] > cut) ? total_seen[s] - cut : 64'd0;
      div  = 64'(calls_seen[s]) - 64'(TRIM_MIN_CALLS);
      q    = (div == 64'd0) ? 64'd0 : rest / div;
      if (q > SAMPLE_MASK) q = SAMPLE_MASK;
      r.trimmed_average = q[TIME_W-1:0];
      r.average_valid   = 1'b1;
    end
    return r;
  endfunction

  // most gaps short, a few long
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap(int idx);
    if (idx >= 700 && idx < 850) return 0;
    if ($urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
  endtask

  task automatic send_item(stim_row_t item, int gap);
    slot_report_t predicted;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= item.command;
    in_slot    <= item.slot;
    in_sample  <= item.sample;
    do @(posedge clk); while (!in_ready);
    predicted = update_slot_stats(item.command, item.slot, item.sample);
    pending_stats.push_back(item.typed ? item.want : predicted);
    items_sent++;
  endtask

  initial begin
    stim_row_t    rows[$];
    stim_row_t    item;
    slot_report_t blank;
    int           pick;
    in_valid   <= 1'b0;
    in_command <= CMD_RECORD;
    in_slot    <= '0;
    in_sample  <= '0;
    rst_n      <= 1'b0;
    error_count   = 0;
    items_sent    = 0;
    for (int i = 0; i < SLOTS; i++) begin
      calls_seen[i] = '0;
      total_seen[i] = '0;
      top_first[i]  = '0;
      top_second[i] = '0;
      low_first[i]  = SAMPLE_MASK;
      low_second[i] = SAMPLE_MASK;
    end
    blank = stats('0, SAMPLE_MASK, '0, '0, 1'b0);

    // empty slots, extreme samples and extreme slot indexes
    rows.push_back(make_row(CMD_READ,    0, '0, 1, blank));
    rows.push_back(make_row(CMD_READ,   63, SAMPLE_MASK, 1, blank));
    rows.push_back(make_row(CMD_RECORD,  0, '0, 1, stats(1, '0, '0, '0, 1'b0)));
    rows.push_back(make_row(CMD_RECORD, 63, SAMPLE_MASK, 1,
                            stats(1, SAMPLE_MASK, SAMPLE_MASK, '0, 1'b0)));
    rows.push_back(make_row(CMD_READ,   63, '0, 1, stats(1, SAMPLE_MASK, SAMPLE_MASK, '0, 1'b0)));
    // exactly four calls, then one more
    rows.push_back(make_row(CMD_RECORD,  1, 10, 0, blank));
    rows.push_back(make_row(CMD_RECORD,  1, 20, 0, blank));
    rows.push_back(make_row(CMD_RECORD,  1, 30, 0, blank));
    rows.push_back(make_row(CMD_RECORD,  1, 40, 0, blank));
    rows.push_back(make_row(CMD_READ,    1, '0, 1, stats(4, 10, 40, '0, 1'b1)));
    rows.push_back(make_row(CMD_RECORD,  1, 100, 0, blank));
    rows.push_back(make_row(CMD_READ,    1, '0, 0, blank));
    // ties on every kept extreme
    repeat (5) rows.push_back(make_row(CMD_RECORD, 2, 7, 0, blank));
    rows.push_back(make_row(CMD_READ,    2, '0, 0, blank));
    // largest possible mean
    repeat (5) rows.push_back(make_row(CMD_RECORD, 3, SAMPLE_MASK, 0, blank));
    rows.push_back(make_row(CMD_READ,    3, '0, 0, blank));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_item(rows[i], sender_gap(items_sent));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      item = make_row(($urandom_range(0, 99) < 30) ? CMD_READ : CMD_RECORD, 0, '0, 0, blank);
      item.slot = ($urandom_range(0, 99) < 60) ? SLOT_W'($urandom_range(8, 15))
                                               : SLOT_W'($urandom_range(0, SLOTS - 1));
      pick = $urandom_range(0, 9);
      case (pick)
        0: item.sample = '0;
        1: item.sample = SAMPLE_MASK[SAMPLE_W-1:0];
        2: item.sample = SAMPLE_W'($urandom_range(0, 1000));
        3, 4, 5: item.sample = SAMPLE_W'({$urandom, $urandom});
        default: item.sample = SAMPLE_W'(1000000 + $urandom_range(0, 5000));
      endcase
      send_item(item, sender_gap(items_sent));
    end
    in_valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d commands sent, %0d results checked, %0d of them carrying a trimmed mean",
             items_sent, results_seen, averages_seen);
    $display("covered empty and full slots, ties, extreme samples and a stalled input");
    if (error_count == 0 && pending_stats.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: random back-pressure, one quiet stretch and one long hold-off
  initial begin
    slot_report_t want;
    int           hold;
    bit           pressure_done;
    out_ready    <= 1'b0;
    results_seen  = 0;
    averages_seen = 0;
    hold          = 0;
    pressure_done = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_average_valid) averages_seen++;
        if (pending_stats.size() == 0) begin
          report_mismatch("result with nothing pending, call_count", 64'(out_call_count), '0);
        end else begin
          want = pending_stats.pop_front();
          if (out_call_count !== want.call_count)
            report_mismatch("call_count", 64'(out_call_count), 64'(want.call_count));
          if (out_min_time !== want.min_time)
            report_mismatch("min_time", 64'(out_min_time), 64'(want.min_time));
          if (out_max_time !== want.max_time)
            report_mismatch("max_time", 64'(out_max_time), 64'(want.max_time));
          if (out_trimmed_average !== want.trimmed_average)
            report_mismatch("trimmed_average", 64'(out_trimmed_average),
                            64'(want.trimmed_average));
          if (out_average_valid !== want.average_valid)
            report_mismatch("average_valid", 64'(out_average_valid), 64'(want.average_valid));
        end
      end
      if (!pressure_done && results_seen >= 500) begin
        pressure_done = 1'b1;
        hold          = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (results_seen >= 200 && results_seen < 350) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        hold = idle_length() - 1;
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

FILE: trimmed_latency_statistics_core.f
design/tls_pkg.sv
design/tls_ram.sv
design/tls_div.sv
design/trimmed_latency_statistics_core.sv
design/tls_checker.sv
sim/trimmed_latency_statistics_core_test.sv
